>>> hw/rtl/tfn_pkg.sv
`timescale 1ns / 1ps
package tfn_pkg;
  localparam int CoordBits = 24;
  localparam int NormFrac  = 14;
  localparam int NormBits  = NormFrac + 2;
  localparam int ProdBits  = 2 * (CoordBits + 1) + 1;
  localparam int MulBits   = 33;
  localparam int DivBits   = 32 + NormFrac;
  localparam int SqrtSteps = 32;

  typedef struct packed {
    logic signed [CoordBits-1:0] pos_x;
    logic signed [CoordBits-1:0] pos_y;
    logic signed [CoordBits-1:0] pos_z;
    logic                        list_end;
  } in_beat_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] out_x;
    logic signed [CoordBits-1:0] out_y;
    logic signed [CoordBits-1:0] out_z;
    logic signed [NormBits-1:0]  norm_x;
    logic signed [NormBits-1:0]  norm_y;
    logic signed [NormBits-1:0]  norm_z;
    logic signed [CoordBits-1:0] tex_u;
    logic signed [CoordBits-1:0] tex_v;
    logic                        run_last;
  } out_beat_t;

  typedef enum logic [2:0] {
    StIdle, StCross, StScale, StSquare, StSqrt, StDivide, StDone
  } state_e;
endpackage

>>> hw/rtl/triangle_face_normal_unit.sv
`timescale 1ns / 1ps
// triangle_face_normal_unit
// Input channel: one vertex beat (x, y, z, list_end) per valid/stall handshake.
// Output channel: per-vertex beats with position, unit normal (Q1.14), tex u/v
// and run_last on the last beat caused by an input.
// The first two vertices of a triangle are held (no output).
// The third starts the shared normal solver; one multiplier serves the cross
// product and the squaring. Steps in order: cross product, one-bit normalising
// shifts, squaring, isqrt, three divisions (one per component) and one done
// state. A degenerate triangle goes from the shifts straight to done. Output
// beats follow one per cycle while the output is not stalled. list_end on a
// partial triangle flushes the held vertices and itself with zero normal,
// first beat in the cycle after accept.
// Input stall is high from accept of a vertex with output until the last
// beat leaves; the next vertex is taken the cycle after. A stall on the output
// holds the current beat unchanged.
// Reset empties the held-vertex count and returns to idle.
module triangle_face_normal_unit import tfn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);
  logic signed [CoordBits-1:0] hx_q [3], hy_q [3], hz_q [3];
  logic [1:0] cnt_q, nout_q, ptr_q;
  logic busy_q, start;
  logic [2:0][NormBits-1:0] nrm_q, dn;
  logic done;
  logic [2:0][CoordBits-1:0] p0, p1, p2;
  logic acc;

  assign in_stall_o = busy_q;
  assign acc = in_valid_i && !busy_q;
  assign start = acc && cnt_q == 2'd2;

  assign p0 = {hz_q[0], hy_q[0], hx_q[0]};
  assign p1 = {hz_q[1], hy_q[1], hx_q[1]};
  assign p2 = {in_data_i.pos_z, in_data_i.pos_y, in_data_i.pos_x};

  tfn_datapath u_dp (
    .clk_i, .rst_ni, .start_i(start), .p0_i(p0), .p1_i(p1), .p2_i(p2),
    .done_o(done), .norm_o(dn)
  );

  always_ff @(posedge clk_i) begin
    if (acc) begin
      hx_q[cnt_q] <= in_data_i.pos_x;
      hy_q[cnt_q] <= in_data_i.pos_y;
      hz_q[cnt_q] <= in_data_i.pos_z;
    end
    if (acc) nrm_q <= '0;
    else if (done) nrm_q <= dn;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; busy_q <= 1'b0; out_valid_o <= 1'b0;
      nout_q <= '0; ptr_q <= '0;
    end else begin
      if (acc) begin
        if (cnt_q == 2'd2) begin
          busy_q <= 1'b1; nout_q <= 2'd2; ptr_q <= '0; cnt_q <= '0;
        end else if (in_data_i.list_end) begin
          busy_q <= 1'b1; out_valid_o <= 1'b1; nout_q <= cnt_q; ptr_q <= '0; cnt_q <= '0;
        end else cnt_q <= cnt_q + 2'd1;
      end
      if (done) out_valid_o <= 1'b1;
      if (out_valid_o && !out_stall_i) begin
        if (ptr_q == nout_q) begin out_valid_o <= 1'b0; busy_q <= 1'b0; end
        else ptr_q <= ptr_q + 2'd1;
      end
    end
  end

  always_comb begin
    out_data_o.out_x  = hx_q[ptr_q];
    out_data_o.out_y  = hy_q[ptr_q];
    out_data_o.out_z  = hz_q[ptr_q];
    out_data_o.norm_x = nrm_q[0];
    out_data_o.norm_y = nrm_q[1];
    out_data_o.norm_z = nrm_q[2];
    out_data_o.tex_u  = hx_q[ptr_q];
    out_data_o.tex_v  = hy_q[ptr_q];
    out_data_o.run_last = (ptr_q == nout_q);
  end
endmodule

>>> hw/rtl/tfn_datapath.sv
`timescale 1ns / 1ps
// Normal solver: one shared multiplier and one compare/subtract path per step.
// Steps in order: cross, scale, square, isqrt, divide (three components), done.
module tfn_datapath import tfn_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [2:0][CoordBits-1:0] p0_i,
  input  logic [2:0][CoordBits-1:0] p1_i,
  input  logic [2:0][CoordBits-1:0] p2_i,
  output logic                      done_o,
  output logic [2:0][NormBits-1:0]  norm_o
);
  state_e st_q, st_d;
  logic [4:0] step_q, step_d;
  logic [1:0] comp_q, comp_d;
  logic [2:0][CoordBits:0] a_q, b_q;
  logic [2:0][ProdBits-1:0] m_q;
  logic [2:0] neg_q;
  logic signed [ProdBits-1:0] acc_q;
  logic [63:0] sum_q, res_q, bit_q;
  logic [DivBits-1:0] dvd_q, dvs_q;
  logic [NormFrac:0] quo_q;
  logic [2:0][NormBits-1:0] norm_q;

  logic signed [MulBits-1:0] mul_a, mul_b;
  logic signed [2*MulBits-1:0] prod;
  logic signed [ProdBits-1:0] cr;
  logic [ProdBits-1:0] mx;
  logic [63:0] trial;
  logic sq_ge, div_ge;
  logic [NormFrac:0] quo_nx;

  // magnitude thresholds are powers of two, so the OR of the three serves as the max
  assign mx = m_q[0] | m_q[1] | m_q[2];

  assign prod   = (2*MulBits)'(mul_a) * (2*MulBits)'(mul_b);
  assign cr     = acc_q - $signed(prod[ProdBits-1:0]);
  assign trial  = res_q + bit_q;
  assign sq_ge  = (sum_q >= trial);
  assign div_ge = (dvd_q >= dvs_q);
  assign quo_nx = {quo_q[NormFrac-1:0], div_ge};
  assign norm_o = norm_q;

  // next state
  always_comb begin
    st_d = st_q;
    step_d = step_q;
    comp_d = comp_q;
    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          st_d = StCross;
          step_d = '0;
          comp_d = '0;
        end
      end
      StCross: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'd5) begin
          step_d = '0;
          st_d = StScale;
        end
      end
      StScale: begin
        if (mx == '0) begin
          st_d = StDone;
        end else if (mx[ProdBits-1:31] == '0 && mx[30]) begin
          st_d = StSquare;
          comp_d = '0;
        end
      end
      StSquare: begin
        comp_d = comp_q + 2'd1;
        if (comp_q == 2'd2) begin
          comp_d = '0;
          step_d = '0;
          st_d = StSqrt;
        end
      end
      StSqrt: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'(SqrtSteps - 1)) begin
          step_d = '0;
          st_d = StDivide;
        end
      end
      StDivide: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'(NormFrac + 1)) begin
          step_d = '0;
          comp_d = comp_q + 2'd1;
          if (comp_q == 2'd2) begin
            comp_d = '0;
            st_d = StDone;
          end
        end
      end
      StDone: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // outputs: done strobe and multiplier operand select
  always_comb begin
    done_o = (st_q == StDone);
    mul_a = '0;
    mul_b = '0;
    unique case (st_q)
      StCross: begin
        case (step_q[2:0])
          3'd0: begin mul_a = MulBits'($signed(a_q[1])); mul_b = MulBits'($signed(b_q[2])); end
          3'd1: begin mul_a = MulBits'($signed(a_q[2])); mul_b = MulBits'($signed(b_q[1])); end
          3'd2: begin mul_a = MulBits'($signed(a_q[2])); mul_b = MulBits'($signed(b_q[0])); end
          3'd3: begin mul_a = MulBits'($signed(a_q[0])); mul_b = MulBits'($signed(b_q[2])); end
          3'd4: begin mul_a = MulBits'($signed(a_q[0])); mul_b = MulBits'($signed(b_q[1])); end
          default: begin
            mul_a = MulBits'($signed(a_q[1]));
            mul_b = MulBits'($signed(b_q[0]));
          end
        endcase
      end
      StSquare: begin
        // scaled magnitudes sit below 2^31
        mul_a = MulBits'(m_q[comp_q][30:0]);
        mul_b = MulBits'(m_q[comp_q][30:0]);
      end
      default: begin end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      step_q <= '0;
      comp_q <= '0;
    end else begin
      st_q <= st_d;
      step_q <= step_d;
      comp_q <= comp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            a_q[i] <= (CoordBits+1)'($signed(p1_i[i])) - (CoordBits+1)'($signed(p0_i[i]));
            b_q[i] <= (CoordBits+1)'($signed(p2_i[i])) - (CoordBits+1)'($signed(p0_i[i]));
            norm_q[i] <= '0;
          end
        end
      end
      StCross: begin
        // even step: first product; odd step: component = first - second
        if (step_q[0]) begin
          neg_q[step_q[2:1]] <= cr[ProdBits-1];
          m_q[step_q[2:1]] <= cr[ProdBits-1] ? -cr : cr;
        end else begin
          acc_q <= $signed(prod[ProdBits-1:0]);
        end
      end
      StScale: begin
        // one bit per cycle until the largest lies in [2^30, 2^31)
        if (mx[ProdBits-1:31] != '0) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
        end else if (mx != '0 && !mx[30]) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
        end
        sum_q <= '0;
      end
      StSquare: begin
        sum_q <= sum_q + prod[63:0];
        res_q <= '0;
        bit_q <= 64'd1 << 62;
      end
      StSqrt: begin
        if (sq_ge) begin
          sum_q <= sum_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      StDivide: begin
        // step 0 loads (m << F) + L/2 and L << F; 15 restoring steps follow
        if (step_q == '0) begin
          dvd_q <= DivBits'({m_q[comp_q][30:0], {NormFrac{1'b0}}}) + DivBits'(res_q[31:1]);
          dvs_q <= DivBits'({res_q[31:0], {NormFrac{1'b0}}});
          quo_q <= '0;
        end else begin
          if (div_ge) dvd_q <= dvd_q - dvs_q;
          dvs_q <= dvs_q >> 1;
          quo_q <= quo_nx;
          if (step_q == 5'(NormFrac + 1))
            norm_q[comp_q] <= neg_q[comp_q] ? -{1'b0, quo_nx} : {1'b0, quo_nx};
        end
      end
      default: begin end
    endcase
  end
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import tfn_pkg::*;

  typedef logic [2:0][NormBits-1:0] nvec_t;

  // Clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  // DUT hookup
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_data_o;

  triangle_face_normal_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Vertices waiting to be driven, and vertex beats expected back
  in_beat_t  vtx_q[$];
  out_beat_t vert_expect_q[$];

  // Predictor copy of the held-vertex store
  logic signed [CoordBits-1:0] hold_x[2], hold_y[2], hold_z[2];
  int unsigned hold_cnt = 0;

  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  localparam int WatchdogLimit = 20000;

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic longint unsigned sqrt_floor(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Unit face normal of (p1 - p0) x (p2 - p0), Q1.14; zero when degenerate
  function automatic nvec_t face_normal(input longint x0, input longint y0, input longint z0,
                                        input longint x1, input longint y1, input longint z1,
                                        input longint x2, input longint y2, input longint z2);
    longint ax, ay, az, bx, by, bz;
    longint cr[3];
    longint unsigned mag[3], top, len, q;
    bit neg[3];
    nvec_t nv;
    nv = '0;
    ax = x1 - x0; ay = y1 - y0; az = z1 - z0;
    bx = x2 - x0; by = y2 - y0; bz = z2 - z0;
    cr[0] = ay * bz - az * by;
    cr[1] = az * bx - ax * bz;
    cr[2] = ax * by - ay * bx;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = cr[i] < 0;
      mag[i] = neg[i] ? -cr[i] : cr[i];
      if (mag[i] > top) top = mag[i];
    end
    if (top == 0) return nv;
    while (top >= (64'd1 << 31)) begin
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
      top >>= 1;
    end
    while (top < (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
      top <<= 1;
    end
    len = sqrt_floor(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << NormFrac) + (len >> 1)) / len;
      nv[i] = neg[i] ? NormBits'(-longint'(q)) : NormBits'(q);
    end
    return nv;
  endfunction

  function automatic out_beat_t vertex_beat(input longint x, input longint y,
                                            input longint z, input nvec_t nv,
                                            input bit last);
    out_beat_t b;
    b.out_x = CoordBits'(x); b.out_y = CoordBits'(y); b.out_z = CoordBits'(z);
    b.norm_x = nv[0]; b.norm_y = nv[1]; b.norm_z = nv[2];
    b.tex_u = CoordBits'(x); b.tex_v = CoordBits'(y);
    b.run_last = last;
    return b;
  endfunction

  // Advance the predictor by one accepted vertex
  task automatic predict_vertex(input in_beat_t v);
    longint cx, cy, cz;
    nvec_t nv;
    cx = $signed(v.pos_x);
    cy = $signed(v.pos_y);
    cz = $signed(v.pos_z);
    if (hold_cnt == 2) begin
      nv = face_normal(hold_x[0], hold_y[0], hold_z[0], hold_x[1], hold_y[1], hold_z[1],
                       cx, cy, cz);
      vert_expect_q = {vert_expect_q, vertex_beat(hold_x[0], hold_y[0], hold_z[0], nv, 1'b0)};
      vert_expect_q = {vert_expect_q, vertex_beat(hold_x[1], hold_y[1], hold_z[1], nv, 1'b0)};
      vert_expect_q = {vert_expect_q, vertex_beat(cx, cy, cz, nv, 1'b1)};
      hold_cnt = 0;
    end else if (v.list_end) begin
      // flush of a partial triangle, zero normal
      for (int i = 0; i < hold_cnt; i++)
        vert_expect_q = {vert_expect_q,
                         vertex_beat(hold_x[i], hold_y[i], hold_z[i], '0, 1'b0)};
      vert_expect_q = {vert_expect_q, vertex_beat(cx, cy, cz, '0, 1'b1)};
      hold_cnt = 0;
    end else begin
      hold_x[hold_cnt] = v.pos_x;
      hold_y[hold_cnt] = v.pos_y;
      hold_z[hold_cnt] = v.pos_z;
      hold_cnt++;
    end
  endtask

  // Mostly short gaps, now and then a long one, sometimes none at all
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: holds each beat until accepted, then optional gap
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_vertex(in_data_i);
        void'(vtx_q.pop_front());
        in_gap = gap_len();
      end
      if (in_valid_i && in_stall_o) begin
        // stalled beat stays put
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (vtx_q.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= vtx_q[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: compares each accepted vertex beat with the oldest expectation
  int out_gap = 0;
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (vert_expect_q.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          want = vert_expect_q.pop_front();
          if (out_data_o.out_x !== want.out_x) report("out_x", out_data_o.out_x, want.out_x);
          if (out_data_o.out_y !== want.out_y) report("out_y", out_data_o.out_y, want.out_y);
          if (out_data_o.out_z !== want.out_z) report("out_z", out_data_o.out_z, want.out_z);
          if (out_data_o.norm_x !== want.norm_x)
            report("norm_x", out_data_o.norm_x, want.norm_x);
          if (out_data_o.norm_y !== want.norm_y)
            report("norm_y", out_data_o.norm_y, want.norm_y);
          if (out_data_o.norm_z !== want.norm_z)
            report("norm_z", out_data_o.norm_z, want.norm_z);
          if (out_data_o.tex_u !== want.tex_u) report("tex_u", out_data_o.tex_u, want.tex_u);
          if (out_data_o.tex_v !== want.tex_v) report("tex_v", out_data_o.tex_v, want.tex_v);
          if (out_data_o.run_last !== want.run_last)
            report("run_last", out_data_o.run_last, want.run_last);
        end
      end
      // receiver stall in runs of random length
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_gap = gap_len();
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on beats accepted on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  function automatic logic signed [CoordBits-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return {1'b1, {(CoordBits-1){1'b0}}};
    if (r == 1) return {1'b0, {(CoordBits-1){1'b1}}};
    if (r < 5) return CoordBits'($urandom_range(0, 8191) - 4096);
    return CoordBits'($urandom);
  endfunction

  task automatic add_vertex(input longint x, input longint y, input longint z,
                            input bit last);
    in_beat_t v;
    v.pos_x = CoordBits'(x); v.pos_y = CoordBits'(y); v.pos_z = CoordBits'(z);
    v.list_end = last;
    vtx_q = {vtx_q, v};
  endtask

  initial begin
    longint mn, mx;
    int kind, shape;
    in_beat_t v;
    mn = -(64'sd1 << (CoordBits - 1));
    mx = (64'sd1 << (CoordBits - 1)) - 1;
    // Directed: plain triangle, extremes, degenerate, flushes, end on third
    add_vertex(0, 0, 0, 0); add_vertex(4096, 0, 0, 0); add_vertex(0, 4096, 0, 0);
    add_vertex(mn, mn, mn, 0); add_vertex(mx, mn, mx, 0); add_vertex(mn, mx, mx, 0);
    add_vertex(mx, mx, mx, 0); add_vertex(mn, mn, mn, 0); add_vertex(mn, mx, mn, 0);
    add_vertex(5, 5, 5, 0); add_vertex(5, 5, 5, 0); add_vertex(5, 5, 5, 0);
    add_vertex(1, 2, 3, 0); add_vertex(2, 4, 6, 0); add_vertex(3, 6, 9, 0);
    add_vertex(mx, 0, mn, 1);
    add_vertex(-1, -1, -1, 0); add_vertex(7, 8, 9, 1);
    add_vertex(0, 0, 0, 0); add_vertex(0, 1, 0, 0); add_vertex(1, 0, 0, 1);
    add_vertex(-4096, 3, mx, 0); add_vertex(1, -1, 0, 1);
    // Random: mostly well-formed triangle runs, some flushes and noise
    for (int n = 0; n < 225; ) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        shape = $urandom_range(1, 4);
        for (int t = 0; t < 3 * shape; t++) begin
          v.pos_x = rand_coord(); v.pos_y = rand_coord(); v.pos_z = rand_coord();
          v.list_end = (t == 3 * shape - 1) ? 1'($urandom_range(0, 1)) : 1'b0;
          vtx_q = {vtx_q, v}; n++;
        end
      end else begin
        v.pos_x = rand_coord(); v.pos_y = rand_coord(); v.pos_z = rand_coord();
        v.list_end = 1'($urandom_range(0, 1));
        vtx_q = {vtx_q, v}; n++;
      end
    end
    // close any partial triangle so every held vertex comes out
    add_vertex(1, 1, 1, 1);
    add_vertex(2, 2, 2, 1);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (vtx_q.size() == 0 && !in_valid_i);
    wait (vert_expect_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
